// File: hdl/ctcgd_pkg.sv
// Shared constants of the CTC greedy decoder.
// No dependencies; imported by the decoder and its checker.
`default_nettype none

package ctcgd_pkg;

  // Width of the label field and of the blank index register.
  localparam int unsigned LabelBits = 6;

  // Blank class index after reset.
  localparam logic [LabelBits-1:0] BlankReset = 6'd63;

endpackage

`default_nettype wire

// File: hdl/ctc_greedy_decoder.sv
// CTC greedy decoder: running argmax per frame plus CTC collapse.
// Depends on ctcgd_pkg.
`default_nettype none

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+-----------------------------------------
// in      | request   | in_valid_i / in_stall_o | score_i, last_in_frame_i,
//         |           |                         | first_of_sequence_i, last_of_sequence_i
// out     | result    | out_valid_o/out_stall_i | label_o, emit_o, sequence_done_o
// cfg     | write     | cfg_valid_i/cfg_ready_o | cfg_data_i (blank index)
//
// One request per cycle sustained unless a frame-ending request waits. A request is
// held in the input register, then the single compare-and-update stage folds it
// into the frame state; a frame-ending request puts its result in the output register.
// Reset (rst_ni low, asynchronous) empties both registers, sets the blank index to 63
// and clears the decode state (after-blank flag set). A stalled result holds the
// output register; requests that do not end a frame keep flowing past it, and only
// a frame-ending request waits for the output register to free up. The configuration
// port is always ready; the user must write it only while the block is idle (unchecked).

module ctc_greedy_decoder
  import ctcgd_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 64,
  parameter int unsigned SCORE_BITS  = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // scores
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire signed [SCORE_BITS-1:0] score_i,
  input  wire                         last_in_frame_i,
  input  wire                         first_of_sequence_i,
  input  wire                         last_of_sequence_i,
  // frame results
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [LabelBits-1:0]        label_o,
  output logic                        emit_o,
  output logic                        sequence_done_o,
  // blank index register
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [LabelBits-1:0]        cfg_data_i
);

  // class index width, position counter width (must hold MAX_CLASSES itself)
  localparam int unsigned ClassBits = $clog2(MAX_CLASSES);
  localparam int unsigned PosBits   = $clog2(MAX_CLASSES + 1);
  localparam int unsigned WideBits  = (ClassBits > LabelBits) ? ClassBits : LabelBits;
  localparam logic [PosBits-1:0] MaxPos = PosBits'(MAX_CLASSES);

  // ---------------- configuration ----------------
  logic [LabelBits-1:0] blank_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= BlankReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      blank_q <= cfg_data_i;
    end
  end

  // ---------------- input register ----------------
  logic                         in_vld_q;
  logic                         in_vld_d;
  logic signed [SCORE_BITS-1:0] score_q;
  logic                         lif_q;
  logic                         fos_q;
  logic                         los_q;
  logic                         in_accept;
  logic                         out_free;
  logic                         advance;

  // output register can take a result this cycle
  assign out_free   = !out_valid_o || !out_stall_i;
  // only a frame-ending request needs a free output slot
  assign advance    = in_vld_q && (!lif_q || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_stall_o ? 1'b1 : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      score_q <= score_i;
      lif_q   <= last_in_frame_i;
      fos_q   <= first_of_sequence_i;
      los_q   <= last_of_sequence_i;
    end
  end

  // ---------------- decode state ----------------
  logic signed [SCORE_BITS-1:0] best_score_q, best_score_d;
  logic [ClassBits-1:0]         best_class_q, best_class_d;
  logic [PosBits-1:0]           pos_q, pos_d;
  logic                         after_blank_q, after_blank_d;
  logic [ClassBits-1:0]         last_emitted_q, last_emitted_d;

  // state as seen by this request (a sequence start clears it first)
  logic signed [SCORE_BITS-1:0] score_eff;
  logic [ClassBits-1:0]         class_eff;
  logic [PosBits-1:0]           pos_eff;
  logic                         ab_eff;
  logic [ClassBits-1:0]         le_eff;

  logic                         take;
  logic                         upd;
  logic [ClassBits-1:0]         class_new;
  logic [WideBits-1:0]          class_wide;
  logic [WideBits-1:0]          blank_wide;
  logic                         is_blank;
  logic                         emit_d;

  always_comb begin
    score_eff = fos_q ? '0 : best_score_q;
    class_eff = fos_q ? '0 : best_class_q;
    pos_eff   = fos_q ? '0 : pos_q;
    ab_eff    = fos_q | after_blank_q;
    le_eff    = fos_q ? '0 : last_emitted_q;

    // classes beyond MAX_CLASSES are ignored; ties keep the earlier class
    take      = pos_eff < MaxPos;
    upd       = take && ((pos_eff == '0) || (score_q > score_eff));
    class_new = upd ? pos_eff[ClassBits-1:0] : class_eff;

    class_wide = WideBits'(class_new);
    blank_wide = WideBits'(blank_q);
    is_blank   = class_wide == blank_wide;
    emit_d     = !is_blank && (ab_eff || (class_new != le_eff));

    if (lif_q) begin
      best_score_d   = '0;
      best_class_d   = '0;
      pos_d          = '0;
      after_blank_d  = is_blank | (ab_eff & !emit_d);
      last_emitted_d = emit_d ? class_new : le_eff;
    end else begin
      best_score_d   = upd ? score_q : score_eff;
      best_class_d   = class_new;
      pos_d          = take ? (pos_eff + PosBits'(1)) : pos_eff;
      after_blank_d  = ab_eff;
      last_emitted_d = le_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q   <= '0;
      best_class_q   <= '0;
      pos_q          <= '0;
      after_blank_q  <= 1'b1;
      last_emitted_q <= '0;
    end else if (advance) begin
      best_score_q   <= best_score_d;
      best_class_q   <= best_class_d;
      pos_q          <= pos_d;
      after_blank_q  <= after_blank_d;
      last_emitted_q <= last_emitted_d;
    end
  end

  // ---------------- output register ----------------
  logic out_vld_q, out_vld_d;
  logic out_load;

  assign out_load  = advance && lif_q;
  assign out_vld_d = out_load | (out_vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      label_o         <= class_wide[LabelBits-1:0];
      emit_o          <= emit_d;
      sequence_done_o <= los_q;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

// File: hdl/ctcgd_checker.sv
// Port-level checker for the CTC greedy decoder, bound to the top level.
// Depends on ctcgd_pkg.
`default_nettype none

module ctcgd_checker
  import ctcgd_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 64
) (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input wire                 last_in_frame_i,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input wire [LabelBits-1:0] label_o,
  input wire                 emit_o,
  input wire                 sequence_done_o,
  input wire                 cfg_valid_i,
  input wire                 cfg_ready_o,
  input wire [LabelBits-1:0] cfg_data_i
);

  logic [LabelBits-1:0] blank_q;
  logic [2:0]           pend_q;
  logic                 frame_in;
  logic                 frame_out;

  assign frame_in  = in_valid_i && !in_stall_o && last_in_frame_i;
  assign frame_out = out_valid_o && !out_stall_i;

  // shadow of the blank register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= BlankReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      blank_q <= cfg_data_i;
    end
  end

  // frame-ending requests taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(frame_in) - 3'(frame_out);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(label_o) && $stable(emit_o)
      && $stable(sequence_done_o))
    else $error("stalled result changed");

  // at most the input and output registers hold pending frames
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("too many frames in flight");

  // no result without a frame end taken in
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result without a frame end");

  // blank winners are never emitted (label is exact only up to 64 classes)
  a_blank_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (MAX_CLASSES <= 64) && out_valid_o && emit_o |-> label_o != blank_q)
    else $error("blank label emitted");

endmodule

bind ctc_greedy_decoder ctcgd_checker #(
  .MAX_CLASSES(MAX_CLASSES)
) u_ctcgd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .last_in_frame_i (last_in_frame_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .label_o         (label_o),
  .emit_o          (emit_o),
  .sequence_done_o (sequence_done_o),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .cfg_data_i      (cfg_data_i)
);

`default_nettype wire

// File: test/ctc_greedy_decoder_test.sv
// Self-checking testbench of the CTC greedy decoder: streams scores, predicts each frame.
// Depends on ctcgd_pkg and ctc_greedy_decoder; needs nothing else.
`default_nettype none

module ctc_greedy_decoder_test;
  import ctcgd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A run is abandoned after this many cycles in which no request, result or
  // register write moves.
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 200;

  typedef struct packed {
    logic [LabelBits-1:0] label;
    logic                 emit;
    logic                 done;
  } frame_result_t;

  // Running argmax and CTC collapse, mirrored in the testbench. Each request
  // that closes a frame leaves one expected result in pending_frames.
  class decode_checker;
    localparam int unsigned FrameClasses = 64;

    frame_result_t        pending_frames[$];
    logic [LabelBits-1:0] blank_index;
    logic signed [15:0]   best_score;
    logic [LabelBits-1:0] best_class;
    int unsigned          class_count;
    bit                   after_blank;
    logic [LabelBits-1:0] last_emitted;
    int unsigned          mismatches;

    function new();
      blank_index = BlankReset;
      mismatches  = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      best_score   = '0;
      best_class   = '0;
      class_count  = 0;
      after_blank  = 1'b1;
      last_emitted = '0;
    endfunction

    function void take_score(logic signed [15:0] score, bit frame_end, bit seq_start,
                             bit seq_end);
      frame_result_t r;
      if (seq_start) clear_sequence();
      // scores past the class limit are dropped until the frame closes
      if (class_count < FrameClasses) begin
        if (class_count == 0 || score > best_score) begin
          best_score = score;
          best_class = class_count[LabelBits-1:0];
        end
        class_count++;
      end
      if (!frame_end) return;
      r.label = best_class;
      r.emit  = 1'b0;
      r.done  = seq_end;
      if (best_class == blank_index) begin
        after_blank = 1'b1;
      end else if (after_blank || best_class != last_emitted) begin
        r.emit       = 1'b1;
        last_emitted = best_class;
        after_blank  = 1'b0;
      end
      pending_frames.insert(pending_frames.size(), r);
      class_count = 0;
      best_score  = '0;
      best_class  = '0;
    endfunction

    task report_mismatch(string note);
      $display("%0t ns mismatch: %s", $time, note);
      mismatches++;
    endtask

    task check_frame(logic [LabelBits-1:0] label, logic emit, logic done);
      frame_result_t want;
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("result label %0d with no frame pending", label));
        return;
      end
      want = pending_frames.pop_front();
      if (label !== want.label)
        report_mismatch($sformatf("label %0d, expected %0d", label, want.label));
      if (emit !== want.emit)
        report_mismatch($sformatf("emit %0b, expected %0b (label %0d)", emit, want.emit,
                                  want.label));
      if (done !== want.done)
        report_mismatch($sformatf("sequence_done %0b, expected %0b (label %0d)", done,
                                  want.done, want.label));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [15:0]   score_i = '0;
  logic                 last_in_frame_i = 1'b0;
  logic                 first_of_sequence_i = 1'b0;
  logic                 last_of_sequence_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [LabelBits-1:0] label_o;
  logic                 emit_o;
  logic                 sequence_done_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [LabelBits-1:0] cfg_data_i = '0;

  decode_checker decoder_model = new();

  int unsigned sent_count = 0;    // requests accepted so far
  int unsigned counted_items = 0; // requests that the block takes into a frame
  int unsigned burst_left = 0;

  ctc_greedy_decoder u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .score_i             (score_i),
    .last_in_frame_i     (last_in_frame_i),
    .first_of_sequence_i (first_of_sequence_i),
    .last_of_sequence_i  (last_of_sequence_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .label_o             (label_o),
    .emit_o              (emit_o),
    .sequence_done_o     (sequence_done_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are sampled in the active region after the rising edge, so the
  // block's outputs still carry their pre-edge values here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      decoder_model.check_frame(label_o, emit_o, sequence_done_o);
  end

  // Watchdog: ends the run once nothing has moved for StallLimit cycles.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no progress for %0d cycles", $time, StallLimit);
    $display("ctc_greedy_decoder regression: fail");
    $finish;
  end

  // Receiver: segments of random stall patterns, plus two long hold-offs
  // while the sender keeps pushing, so the block fills and stalls its input.
  initial begin : result_sink
    int unsigned mode;
    int unsigned seg_len;
    int unsigned holds;
    bit          toggle;
    holds  = 0;
    toggle = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(16, 128);
      if (holds < 2 && sent_count >= 150 + 450 * holds) begin
        holds++;
        repeat (HoldCycles) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      repeat (seg_len) begin
        @(negedge clk_i);
        toggle = !toggle;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= toggle;
        endcase
      end
    end
  end

  // One request; valid stays high from one request to the next within a burst.
  task automatic send_request(input logic signed [15:0] score, input bit frame_end,
                              input bit seq_start, input bit seq_end);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
    end
    in_valid_i          <= 1'b1;
    score_i             <= score;
    last_in_frame_i     <= frame_end;
    first_of_sequence_i <= seq_start;
    last_of_sequence_i  <= seq_end;
    do @(posedge clk_i); while (in_stall_o);
    decoder_model.take_score(score, frame_end, seq_start, seq_end);
    burst_left--;
    sent_count++;
  endtask

  // Blank index is only written once the block has drained.
  task automatic write_blank(input logic [LabelBits-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoder_model.pending_frames.size() != 0) @(posedge clk_i);
    // requests that close no frame may still sit in the pipeline
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    decoder_model.blank_index = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One frame of len scores. With winner >= 0 that class gets the top score
  // (later classes may tie it and must lose); otherwise scores are free.
  task automatic send_frame(input int unsigned len, input int winner, input bit seq_start,
                            input bit seq_end);
    int                 top_v;
    int                 lo_v;
    int unsigned        style;
    logic signed [15:0] s;
    bit                 fos;
    bit                 los;
    style = $urandom_range(0, 3);
    top_v = (style == 0) ? 32767 : int'($urandom_range(0, 32967)) - 200;
    for (int unsigned i = 0; i < len; i++) begin
      lo_v = (style == 0) ? -32768 : int'($urandom_range(0, top_v + 32767)) - 32768;
      fos  = (seq_start && i == 0) || (i > 0 && $urandom_range(0, 199) == 0);
      los  = seq_end || ($urandom_range(0, 29) == 0);
      if (i >= 64 && $urandom_range(0, 1) == 0)
        s = 16'sh7fff;  // beyond the class limit, must be ignored
      else if (winner >= 0 && i == winner)
        s = 16'(top_v);
      else if (winner >= 0 && i > winner && $urandom_range(0, 3) == 0)
        s = 16'(top_v);
      else if (winner >= 0)
        s = 16'(lo_v);
      else if (style < 2)
        s = 16'($urandom);
      else
        s = 16'(int'($urandom_range(0, 4)) - 2);
      if (i < 64) counted_items++;
      send_request(s, i == len - 1, fos, los);
    end
  endtask

  // Mostly well-formed sequences; a few lack their opening flag.
  task automatic send_sequence();
    int unsigned frames;
    int unsigned len;
    int unsigned pick;
    int unsigned blank;
    int          winner;
    int          prev;
    bit          opened;
    frames = $urandom_range(1, 6);
    prev   = -1;
    opened = ($urandom_range(0, 9) != 0);
    blank  = decoder_model.blank_index;
    for (int unsigned f = 0; f < frames; f++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 64);
      else len = $urandom_range(65, 72);
      pick = $urandom_range(0, 99);
      if (pick < 30 && prev >= 0) begin
        winner = prev;  // repeat of the last winner
        if (len <= prev) len = prev + 1;
      end else if (pick < 45 && (blank < 16 || pick < 33)) begin
        winner = blank;
        if (len <= blank) len = blank + 1;
      end else if (pick < 60) begin
        winner = -1;
      end else begin
        winner = $urandom_range(0, ((len < 64) ? len : 64) - 1);
      end
      send_frame(len, winner, opened && f == 0, f == frames - 1);
      if (winner >= 0) prev = winner;
    end
  endtask

  task automatic run_phase();
    int unsigned start_count;
    start_count = counted_items;
    while (counted_items - start_count < PhaseItems) send_sequence();
  endtask

  // Directed frames, blank index 2.
  task automatic run_directed();
    // single-class frame at the lowest score
    send_request(16'sh8000, 1'b1, 1'b1, 1'b0);
    // tie at the top score: class 0 wins, repeats the last label
    send_request(16'sh7fff, 1'b0, 1'b0, 1'b0);
    send_request(16'sh7fff, 1'b1, 1'b0, 1'b0);
    // blank wins
    send_request(-16'sd1, 1'b0, 1'b0, 1'b0);
    send_request(16'sh8000, 1'b0, 1'b0, 1'b0);
    send_request(16'sh7fff, 1'b1, 1'b0, 1'b0);
    // same label as before the blank, emitted again
    send_request(16'sd0, 1'b1, 1'b0, 1'b0);
    // stray sequence end on a score that closes no frame
    send_request(-16'sd5, 1'b0, 1'b0, 1'b1);
    send_request(16'sd10, 1'b1, 1'b0, 1'b0);
    // repeat of class 1 without a blank: held back
    send_request(-16'sd300, 1'b0, 1'b0, 1'b0);
    send_request(16'sd255, 1'b1, 1'b0, 1'b0);
    // new sequence opened mid-frame, ends the sequence
    send_request(16'sd100, 1'b0, 1'b1, 1'b0);
    send_request(16'sd7, 1'b0, 1'b0, 1'b0);
    send_request(16'sd50, 1'b0, 1'b1, 1'b1);
    send_request(16'sd60, 1'b1, 1'b0, 1'b1);
    // equal negative scores, first class kept
    send_request(-16'sd2, 1'b0, 1'b1, 1'b0);
    send_request(-16'sd2, 1'b0, 1'b0, 1'b0);
    send_request(-16'sd3, 1'b1, 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_phase();  // blank index at its reset value
    write_blank(6'd2);
    run_directed();
    run_phase();
    write_blank(6'd0);
    run_phase();
    write_blank(6'($urandom_range(1, 62)));
    run_phase();
    write_blank(6'd63);
    run_phase();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoder_model.pending_frames.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (decoder_model.pending_frames.size() != 0)
      decoder_model.report_mismatch("frames left without a result");
    if (decoder_model.mismatches == 0)
      $display("ctc_greedy_decoder regression: pass");
    else
      $display("ctc_greedy_decoder regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
hdl/ctcgd_pkg.sv
hdl/ctc_greedy_decoder.sv
hdl/ctcgd_checker.sv
test/ctc_greedy_decoder_test.sv
